>>> hdl/ccr_pkg.sv
// ccr_pkg: shared types, constants and arithmetic helpers of the circle collision block
// used by ccr_front, ccr_fifo, ccr_back and circle_collision_resolve; no dependencies
package ccr_pkg;

  localparam int FRAC_BITS = 16;
  localparam logic [63:0] ONE_Q = 64'd1 << FRAC_BITS;
  localparam logic [63:0] RESTITUTION_Q = ((64'd4 << FRAC_BITS) + 64'd5) / 64'd10;
  localparam logic [16:0] BOUNCE_GAIN = 17'(ONE_Q + RESTITUTION_Q);

  localparam logic [30:0] ITS_RESET = 31'd3932160;

  localparam int SQRT_STEPS = 32;
  localparam int DIV_STEPS = FRAC_BITS + 1;
  localparam int WORK_STAGES = SQRT_STEPS + DIV_STEPS;
  localparam int POST_STAGES = 5;
  localparam int PIPE_STAGES = WORK_STAGES + POST_STAGES;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

  localparam int IN_W = 400;
  localparam int OUT_W = 296;

  localparam logic signed [63:0] MAX32 = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [63:0] MIN32 = -64'sh0000_0000_8000_0000;

  typedef struct packed {
    logic              hit;
    logic [63:0]       pos_a;
    logic [63:0]       old_a;
    logic [63:0]       pos_b;
    logic [63:0]       old_b;
    logic signed [32:0] dx;
    logic signed [32:0] dy;
    logic [31:0]       sep;
    logic [63:0]       d2;
    logic [31:0]       mb;
    logic [40:0]       tot;
  } ccr_item_t;

  function automatic logic signed [63:0] shr_tz(input logic signed [63:0] v);
    logic [63:0] m;
    m = v[63] ? 64'(-v) : 64'(v);
    m = m >> FRAC_BITS;
    return v[63] ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic [31:0] sat32(input logic signed [63:0] v);
    logic [31:0] r;
    if (v > MAX32) r = 32'h7FFF_FFFF;
    else if (v < MIN32) r = 32'h8000_0000;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic [42:0] div_step(input logic [41:0] r, input logic b,
                                           input logic [40:0] d);
    logic [41:0] t;
    t = {r[40:0], b};
    if (t >= {1'b0, d}) return {t - {1'b0, d}, 1'b1};
    else return {t, 1'b0};
  endfunction

endpackage

>>> hdl/ccr_front.sv
// ccr_front: input side, squares the center distance and flags overlapping pairs
// depends on ccr_pkg; feeds ccr_fifo
module ccr_front (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  input  logic [ccr_pkg::IN_W-1:0] s_axis_tdata,
  input  logic                     full_i,
  output logic                     push_o,
  output ccr_pkg::ccr_item_t       item_o
);

  typedef struct packed {
    logic [63:0]        pos_a;
    logic [63:0]        old_a;
    logic [63:0]        pos_b;
    logic [63:0]        old_b;
    logic signed [32:0] dx;
    logic signed [32:0] dy;
    logic               big;
    logic [63:0]        a2;
    logic [63:0]        b2;
    logic [63:0]        sep2;
    logic [31:0]        sep;
    logic [47:0]        maprod;
    logic [31:0]        mb;
  } st1_t;

  st1_t s1_d, s1_q;
  ccr_pkg::ccr_item_t s2_d, s2_q;
  logic v1_q, v2_q;
  logic en;

  assign en = !v2_q || !full_i;
  assign s_axis_tready = en;
  assign push_o = v2_q && !full_i;
  assign item_o = s2_q;

  always_comb begin
    logic signed [31:0] pax, pay, pbx, pby;
    logic [32:0] mdx, mdy;
    pax = s_axis_tdata[63:32];
    pay = s_axis_tdata[31:0];
    pbx = s_axis_tdata[191:160];
    pby = s_axis_tdata[159:128];
    s1_d.pos_a = s_axis_tdata[63:0];
    s1_d.old_a = s_axis_tdata[127:64];
    s1_d.pos_b = s_axis_tdata[191:128];
    s1_d.old_b = s_axis_tdata[255:192];
    s1_d.dx = 33'(pbx) - 33'(pax);
    s1_d.dy = 33'(pby) - 33'(pay);
    mdx = s1_d.dx[32] ? 33'(-s1_d.dx) : 33'(s1_d.dx);
    mdy = s1_d.dy[32] ? 33'(-s1_d.dy) : 33'(s1_d.dy);
    s1_d.big = mdx[32] | mdy[32];
    s1_d.a2 = 64'(mdx[31:0]) * 64'(mdx[31:0]);
    s1_d.b2 = 64'(mdy[31:0]) * 64'(mdy[31:0]);
    s1_d.sep = 32'(s_axis_tdata[286:256]) + 32'(s_axis_tdata[317:287]);
    s1_d.sep2 = 64'(s1_d.sep) * 64'(s1_d.sep);
    s1_d.maprod = 48'(s_axis_tdata[349:318]) * 48'(s_axis_tdata[397:382]);
    s1_d.mb = s_axis_tdata[381:350];
  end

  always_comb begin
    logic [64:0] d2;
    logic [39:0] ma;
    d2 = 65'(s1_q.a2) + 65'(s1_q.b2);
    ma = s1_q.maprod[47:8];
    s2_d.hit = !s1_q.big && (d2 < 65'(s1_q.sep2)) && (d2 != '0);
    s2_d.pos_a = s1_q.pos_a;
    s2_d.old_a = s1_q.old_a;
    s2_d.pos_b = s1_q.pos_b;
    s2_d.old_b = s1_q.old_b;
    s2_d.dx = s1_q.dx;
    s2_d.dy = s1_q.dy;
    s2_d.sep = s1_q.sep;
    s2_d.d2 = d2[63:0];
    if (ma == '0 && s1_q.mb == '0) begin
      s2_d.mb = 32'd1;
      s2_d.tot = 41'd2;
    end else begin
      s2_d.mb = s1_q.mb;
      s2_d.tot = 41'(ma) + 41'(s1_q.mb);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en) begin
      v1_q <= s_axis_tvalid;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_q <= s1_d;
      s2_q <= s2_d;
    end
  end

endmodule

>>> hdl/ccr_fifo.sv
// ccr_fifo: short queue of classified pairs between the front and back parts
// depends on ccr_pkg
module ccr_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  ccr_pkg::ccr_item_t data_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               empty_o,
  output ccr_pkg::ccr_item_t data_o
);

  ccr_pkg::ccr_item_t mem_q [ccr_pkg::QUEUE_DEPTH];
  logic [ccr_pkg::QUEUE_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [ccr_pkg::QUEUE_PTR_W:0] cnt_q;

  assign full_o = cnt_q == (ccr_pkg::QUEUE_PTR_W + 1)'(ccr_pkg::QUEUE_DEPTH);
  assign empty_o = cnt_q == '0;
  assign data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop_i) rd_ptr_q <= rd_ptr_q + 1'b1;
      if (push_i && !pop_i) cnt_q <= cnt_q + 1'b1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= data_i;
  end

endmodule

>>> hdl/ccr_back.sv
// ccr_back: pipelined square root, weight and direction dividers, then the push-apart
// and bounce arithmetic with the output register; depends on ccr_pkg
module ccr_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [30:0]               its_i,
  input  logic                      item_valid_i,
  input  ccr_pkg::ccr_item_t        item_i,
  output logic                      pop_o,
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [ccr_pkg::OUT_W-1:0] m_axis_tdata
);

  localparam int NS = ccr_pkg::WORK_STAGES;
  localparam int NP = ccr_pkg::PIPE_STAGES;

  typedef struct packed {
    ccr_pkg::ccr_item_t it;
    logic [34:0] sq_rem;
    logic [31:0] sq_root;
    logic [41:0] w_r;
    logic [16:0] w_q;
    logic [41:0] x_r;
    logic [16:0] x_q;
    logic [41:0] y_r;
    logic [16:0] y_q;
  } work_t;

  typedef struct packed {
    ccr_pkg::ccr_item_t it;
    logic [16:0] wa;
    logic [16:0] wb;
    logic signed [32:0] vax, vay, vbx, vby;
    logic signed [50:0] fdx_p, fdy_p;
    logic signed [51:0] qx_p, qy_p;
    logic [33:0] ka_p, kb_p;
  } p1_t;

  typedef struct packed {
    ccr_pkg::ccr_item_t it;
    logic [16:0] wa;
    logic [16:0] wb;
    logic signed [32:0] vax, vay, vbx, vby;
    logic signed [34:0] fdx, fdy;
    logic signed [36:0] q;
    logic [17:0] ka, kb;
    logic signed [33:0] dvx, dvy, rvx, rvy;
  } p2_t;

  typedef struct packed {
    ccr_pkg::ccr_item_t it;
    logic signed [32:0] vax, vay, vbx, vby;
    logic qpos;
    logic signed [52:0] fa_x, fa_y, fb_x, fb_y;
    logic [51:0] sh;
    logic [46:0] sl;
    logic signed [52:0] ga_x, ga_y, gb_x, gb_y;
  } p3_t;

  typedef struct packed {
    ccr_pkg::ccr_item_t it;
    logic signed [37:0] nax, nay, nbx, nby;
    logic [30:0] s;
    logic bounce;
    logic signed [37:0] nvax, nvay, nvbx, nvby;
  } p4_t;

  work_t wk_d [NS];
  work_t wk_q [NS];
  p1_t p1_d, p1_q;
  p2_t p2_d, p2_q;
  p3_t p3_d, p3_q;
  p4_t p4_d, p4_q;
  logic [ccr_pkg::OUT_W-1:0] out_d, out_q;
  logic [NP-1:0] vld_q;
  logic en;

  assign en = !vld_q[NP-1] || m_axis_tready;
  assign pop_o = en && item_valid_i;
  assign m_axis_tvalid = vld_q[NP-1];
  assign m_axis_tdata = out_q;

  for (genvar k = 0; k < NS; k++) begin : g_work
    localparam int PI = (k < ccr_pkg::SQRT_STEPS) ? 63 - 2 * k : 1;
    localparam int KP = (k == 0) ? 0 : k - 1;

    always_comb begin
      work_t w;
      logic [34:0] t;
      logic [34:0] trial;
      logic [42:0] dr;
      logic [32:0] mx, my;
      if (k == 0) begin
        w.it = item_i;
        w.sq_rem = '0;
        w.sq_root = '0;
        w.w_r = 42'(item_i.mb >> 1);
        w.w_q = '0;
        w.x_r = '0;
        w.x_q = '0;
        w.y_r = '0;
        w.y_q = '0;
      end else begin
        w = wk_q[KP];
      end
      if (k < ccr_pkg::SQRT_STEPS) begin
        t = {w.sq_rem[32:0], w.it.d2[PI -: 2]};
        trial = {1'b0, w.sq_root, 2'b01};
        if (t >= trial) begin
          w.sq_rem = t - trial;
          w.sq_root = {w.sq_root[30:0], 1'b1};
        end else begin
          w.sq_rem = t;
          w.sq_root = {w.sq_root[30:0], 1'b0};
        end
      end
      if (k < ccr_pkg::DIV_STEPS) begin
        dr = ccr_pkg::div_step(w.w_r, (k == 0) ? w.it.mb[0] : 1'b0, w.it.tot);
        w.w_r = dr[42:1];
        w.w_q = {w.w_q[15:0], dr[0]};
      end
      mx = w.it.dx[32] ? 33'(-w.it.dx) : 33'(w.it.dx);
      my = w.it.dy[32] ? 33'(-w.it.dy) : 33'(w.it.dy);
      if (k >= ccr_pkg::SQRT_STEPS) begin
        if (k == ccr_pkg::SQRT_STEPS) begin
          w.x_r = 42'(mx >> 1);
          w.y_r = 42'(my >> 1);
        end
        dr = ccr_pkg::div_step(w.x_r, (k == ccr_pkg::SQRT_STEPS) ? mx[0] : 1'b0,
                               41'(w.sq_root));
        w.x_r = dr[42:1];
        w.x_q = {w.x_q[15:0], dr[0]};
        dr = ccr_pkg::div_step(w.y_r, (k == ccr_pkg::SQRT_STEPS) ? my[0] : 1'b0,
                               41'(w.sq_root));
        w.y_r = dr[42:1];
        w.y_q = {w.y_q[15:0], dr[0]};
      end
      wk_d[k] = w;
    end

    always_ff @(posedge clk_i) begin
      if (en) wk_q[k] <= wk_d[k];
    end
  end

  // direction, overlap vector and relative velocity products
  always_comb begin
    work_t w;
    logic signed [17:0] dirx, diry;
    logic signed [32:0] dd;
    logic signed [33:0] vrx, vry;
    w = wk_q[NS-1];
    dirx = w.it.dx[32] ? -$signed({1'b0, w.x_q}) : $signed({1'b0, w.x_q});
    diry = w.it.dy[32] ? -$signed({1'b0, w.y_q}) : $signed({1'b0, w.y_q});
    dd = $signed({1'b0, w.sq_root}) - $signed({1'b0, w.it.sep});
    p1_d.it = w.it;
    p1_d.wa = w.w_q;
    p1_d.wb = 17'(ccr_pkg::ONE_Q) - w.w_q;
    p1_d.vax = 33'($signed(w.it.pos_a[63:32])) - 33'($signed(w.it.old_a[63:32]));
    p1_d.vay = 33'($signed(w.it.pos_a[31:0])) - 33'($signed(w.it.old_a[31:0]));
    p1_d.vbx = 33'($signed(w.it.pos_b[63:32])) - 33'($signed(w.it.old_b[63:32]));
    p1_d.vby = 33'($signed(w.it.pos_b[31:0])) - 33'($signed(w.it.old_b[31:0]));
    vrx = 34'(p1_d.vax) - 34'(p1_d.vbx);
    vry = 34'(p1_d.vay) - 34'(p1_d.vby);
    p1_d.fdx_p = 51'(dirx) * 51'(dd);
    p1_d.fdy_p = 51'(diry) * 51'(dd);
    p1_d.qx_p = 52'(dirx) * 52'(vrx);
    p1_d.qy_p = 52'(diry) * 52'(vry);
    p1_d.ka_p = 34'(w.w_q) * 34'(ccr_pkg::BOUNCE_GAIN);
    p1_d.kb_p = 34'(p1_d.wb) * 34'(ccr_pkg::BOUNCE_GAIN);
  end

  always_comb begin
    logic signed [63:0] t;
    p2_d.it = p1_q.it;
    p2_d.wa = p1_q.wa;
    p2_d.wb = p1_q.wb;
    p2_d.vax = p1_q.vax;
    p2_d.vay = p1_q.vay;
    p2_d.vbx = p1_q.vbx;
    p2_d.vby = p1_q.vby;
    t = ccr_pkg::shr_tz(64'(p1_q.fdx_p));
    p2_d.fdx = t[34:0];
    t = ccr_pkg::shr_tz(64'(p1_q.fdy_p));
    p2_d.fdy = t[34:0];
    t = ccr_pkg::shr_tz(64'(p1_q.qx_p) + 64'(p1_q.qy_p));
    p2_d.q = t[36:0];
    p2_d.ka = 18'(p1_q.ka_p >> ccr_pkg::FRAC_BITS);
    p2_d.kb = 18'(p1_q.kb_p >> ccr_pkg::FRAC_BITS);
    p2_d.dvx = 34'(p1_q.vbx) - 34'(p1_q.vax);
    p2_d.dvy = 34'(p1_q.vby) - 34'(p1_q.vay);
    p2_d.rvx = 34'(p1_q.vax) - 34'(p1_q.vbx);
    p2_d.rvy = 34'(p1_q.vay) - 34'(p1_q.vby);
  end

  always_comb begin
    logic [36:0] m;
    logic signed [17:0] wa_s, wb_s;
    logic signed [18:0] ka_s, kb_s;
    m = p2_q.q[36] ? 37'(-p2_q.q) : 37'(p2_q.q);
    wa_s = $signed({1'b0, p2_q.wa});
    wb_s = $signed({1'b0, p2_q.wb});
    ka_s = $signed({1'b0, p2_q.ka});
    kb_s = $signed({1'b0, p2_q.kb});
    p3_d.it = p2_q.it;
    p3_d.vax = p2_q.vax;
    p3_d.vay = p2_q.vay;
    p3_d.vbx = p2_q.vbx;
    p3_d.vby = p2_q.vby;
    p3_d.qpos = !p2_q.q[36] && (p2_q.q != '0);
    p3_d.fa_x = 53'(p2_q.fdx) * 53'(wa_s);
    p3_d.fa_y = 53'(p2_q.fdy) * 53'(wa_s);
    p3_d.fb_x = 53'(p2_q.fdx) * 53'(wb_s);
    p3_d.fb_y = 53'(p2_q.fdy) * 53'(wb_s);
    p3_d.sh = 52'(m[36:16]) * 52'(its_i);
    p3_d.sl = 47'(m[15:0]) * 47'(its_i);
    p3_d.ga_x = 53'(p2_q.dvx) * 53'(ka_s);
    p3_d.ga_y = 53'(p2_q.dvy) * 53'(ka_s);
    p3_d.gb_x = 53'(p2_q.rvx) * 53'(kb_s);
    p3_d.gb_y = 53'(p2_q.rvy) * 53'(kb_s);
  end

  always_comb begin
    logic signed [63:0] t;
    logic [52:0] sf;
    p4_d.it = p3_q.it;
    t = 64'($signed(p3_q.it.pos_a[63:32])) + ccr_pkg::shr_tz(64'(p3_q.fa_x));
    p4_d.nax = t[37:0];
    t = 64'($signed(p3_q.it.pos_a[31:0])) + ccr_pkg::shr_tz(64'(p3_q.fa_y));
    p4_d.nay = t[37:0];
    t = 64'($signed(p3_q.it.pos_b[63:32])) - ccr_pkg::shr_tz(64'(p3_q.fb_x));
    p4_d.nbx = t[37:0];
    t = 64'($signed(p3_q.it.pos_b[31:0])) - ccr_pkg::shr_tz(64'(p3_q.fb_y));
    p4_d.nby = t[37:0];
    t = 64'(p3_q.vax) + ccr_pkg::shr_tz(64'(p3_q.ga_x));
    p4_d.nvax = t[37:0];
    t = 64'(p3_q.vay) + ccr_pkg::shr_tz(64'(p3_q.ga_y));
    p4_d.nvay = t[37:0];
    t = 64'(p3_q.vbx) + ccr_pkg::shr_tz(64'(p3_q.gb_x));
    p4_d.nvbx = t[37:0];
    t = 64'(p3_q.vby) + ccr_pkg::shr_tz(64'(p3_q.gb_y));
    p4_d.nvby = t[37:0];
    sf = 53'(p3_q.sh) + 53'(p3_q.sl >> ccr_pkg::FRAC_BITS);
    p4_d.s = (sf > 53'h7FFF_FFFF) ? 31'h7FFF_FFFF : sf[30:0];
    p4_d.bounce = p3_q.qpos && (p4_d.s != '0);
  end

  // result packing: new_pos_a, new_old_a, new_pos_b, new_old_b, closing_speed, contact
  always_comb begin
    logic [31:0] ax, ay, bx, by;
    logic [63:0] npa, noa, npb, nob;
    logic [31:0] spd;
    ax = ccr_pkg::sat32(64'(p4_q.nax));
    ay = ccr_pkg::sat32(64'(p4_q.nay));
    bx = ccr_pkg::sat32(64'(p4_q.nbx));
    by = ccr_pkg::sat32(64'(p4_q.nby));
    npa = p4_q.it.pos_a;
    noa = p4_q.it.old_a;
    npb = p4_q.it.pos_b;
    nob = p4_q.it.old_b;
    spd = '0;
    if (p4_q.it.hit) begin
      npa = {ax, ay};
      npb = {bx, by};
      if (p4_q.bounce) begin
        noa = {ccr_pkg::sat32(64'($signed(ax)) - 64'(p4_q.nvax)),
               ccr_pkg::sat32(64'($signed(ay)) - 64'(p4_q.nvay))};
        nob = {ccr_pkg::sat32(64'($signed(bx)) - 64'(p4_q.nvbx)),
               ccr_pkg::sat32(64'($signed(by)) - 64'(p4_q.nvby))};
        spd = {1'b0, p4_q.s};
      end
    end
    out_d = {7'b0, p4_q.it.hit, spd, nob, npb, noa, npa};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NP-2:0], item_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p1_q <= p1_d;
      p2_q <= p2_d;
      p3_q <= p3_d;
      p4_q <= p4_d;
      out_q <= out_d;
    end
  end

endmodule

>>> hdl/circle_collision_resolve.sv
// circle_collision_resolve: top level of the Verlet circle pair collision block
// depends on ccr_pkg, ccr_front, ccr_fifo and ccr_back
//
// Takes one pair of circles per beat and returns one result beat per pair, in order.
// A pair is accepted every cycle while results are taken. On its way to the result
// beat, a pair passes the 32-step square root pipeline followed by the 17-step
// direction divider pipeline in the back part. A four-beat queue between the
// classifying front part and the back part absorbs short output stalls.
// inverse_time_step is written through cfg_we_i and cfg_wdata_i and resets to 60.0
// in Q15.16; write it only while no pair is in flight.
module circle_collision_resolve (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [30:0]               cfg_wdata_i,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  // pos_a, old_a, pos_b, old_b, radius_a, radius_b, mass_a, mass_b, mass_scale_a
  input  logic [ccr_pkg::IN_W-1:0]  s_axis_tdata,
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  // new_pos_a, new_old_a, new_pos_b, new_old_b, closing_speed, contact
  output logic [ccr_pkg::OUT_W-1:0] m_axis_tdata
);

  logic [30:0] its_q;
  logic push, full, pop, empty;
  ccr_pkg::ccr_item_t front_item, queue_item;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      its_q <= ccr_pkg::ITS_RESET;
    end else if (cfg_we_i) begin
      its_q <= cfg_wdata_i;
    end
  end

  ccr_front u_front (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .full_i (full),
    .push_o (push),
    .item_o (front_item)
  );

  ccr_fifo u_fifo (
    .clk_i,
    .rst_ni,
    .push_i  (push),
    .data_i  (front_item),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .data_o  (queue_item)
  );

  ccr_back u_back (
    .clk_i,
    .rst_ni,
    .its_i        (its_q),
    .item_valid_i (!empty),
    .item_i       (queue_item),
    .pop_o        (pop),
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata
  );

endmodule
